// ===== rtl/core/ndvf_pkg.sv =====
`default_nettype none

package ndvf_pkg;

   localparam int COMP_W     = 16;
   localparam int ACC_W      = 41;
   localparam int VDIM_W     = 9;
   localparam int VEC_IDX_W  = 16;
   localparam int KEPT_CNT_W = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM       = 1'd1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ndvf_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/ndvf_if.sv =====
`default_nettype none

interface ndvf_req_if import ndvf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COMP_W-1:0] component;
   logic                     new_set;

   modport source (output valid, component, new_set, input ready);
   modport sink   (input valid, component, new_set, output ready);
endinterface

interface ndvf_rsp_if import ndvf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VEC_IDX_W-1:0]  vector_index;
   logic                  kept;
   logic                  store_overflow;
   logic [KEPT_CNT_W-1:0] kept_count;

   modport source (output valid, vector_index, kept, store_overflow, kept_count, input ready);
   modport sink   (input valid, vector_index, kept, store_overflow, kept_count, output ready);
endinterface

interface ndvf_csr_if import ndvf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ACC_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/near_duplicate_vector_filter_unit.sv =====
// Near-duplicate vector filter.
// req_chan takes one signed 16-bit component per transaction; new_set on a
// component empties the kept store and starts vector 0. After vector_dim
// components (csr register 1) the block sends one rsp_chan transaction with
// the vector index, whether it was kept (no stored vector has squared
// distance below csr register 0), the overflow flag and the store fill.
// csr_chan is always ready; write it only while the block is idle.
// Each component runs through the shared read / square / accumulate
// pipeline on the kept-store and accumulator memories, one stored vector
// per cycle, plus pipeline fill and drain. The result of the last
// component is registered in the output register once the pipeline
// has drained.
// A finished result waits in the output register; the next component is
// still taken. If that register is still full when the following vector
// ends, the block holds until rsp_chan.ready.
// Reset empties the store, zeroes the counters and sets the threshold to 0
// and the dimension to 1. Store memory contents are not cleared.
`default_nettype none

module near_duplicate_vector_filter_unit import ndvf_pkg::*; #(
   parameter int DIM_MAX  = 256,
   parameter int MAX_KEPT = 64
) (
   input wire logic   clock,
   input wire logic   reset,
   ndvf_req_if.sink   req_chan,
   ndvf_rsp_if.source rsp_chan,
   ndvf_csr_if.sink   csr_chan
);

   localparam int PosW  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam int DimW  = $clog2(DIM_MAX + 1);
   localparam int CmpW  = (DimW > VDIM_W) ? DimW : VDIM_W;
   localparam int JW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CntW  = $clog2(MAX_KEPT + 1);
   localparam int Depth = MAX_KEPT * DIM_MAX;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

   // configuration
   logic [ACC_W-1:0]  thr_ff;
   logic [VDIM_W-1:0] dim_ff;

   // control
   ndvf_state_type    state_ff, state_in;
   logic [CntW-1:0]   cnt_ff;
   logic [VEC_IDX_W-1:0] vec_ff;
   logic [PosW-1:0]   pos_ff;
   logic [CntW-1:0]   j_ff;
   logic              last_ff;
   logic              dup_ff;
   logic signed [COMP_W-1:0] comp_ff;

   // pipeline
   logic              s1_vld_ff, s2_vld_ff;
   logic [JW-1:0]     s1_j_ff, s2_j_ff;
   logic signed [COMP_W-1:0] store_rd_ff;
   logic [ACC_W-1:0]  acc_rd_ff;
   logic [ACC_W-1:0]  acc_old_ff;
   logic [2*COMP_W-1:0] sq_ff;

   // result register
   logic                  rsp_vld_ff;
   logic [VEC_IDX_W-1:0]  rsp_idx_ff;
   logic                  rsp_kept_ff;
   logic                  rsp_ovf_ff;
   logic [KEPT_CNT_W-1:0] rsp_cnt_ff;

   logic signed [COMP_W-1:0] store_mem [Depth];
   logic [ACC_W-1:0]         acc_mem [MAX_KEPT];

   logic              accept, issue, drained, finish, rsp_free;
   logic [CntW-1:0]   cnt_eff;
   logic [PosW-1:0]   pos_eff;
   logic [CmpW-1:0]   eff_dim;
   logic              last_eff;
   logic              wr_ok;
   logic [AddrW-1:0]  wr_addr, rd_addr;
   logic [COMP_W:0]   diff, diff_neg;
   logic [COMP_W-1:0] mag;
   logic [2*COMP_W-1:0] sq;
   logic [ACC_W:0]    sum;
   logic [ACC_W-1:0]  sat;
   logic              room;
   logic [CntW-1:0]   cnt_next;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_vld_ff || rsp_chan.ready;
   assign issue          = (state_ff == ST_RUN) && (j_ff < cnt_ff);
   assign drained        = (state_ff == ST_RUN) && (j_ff == cnt_ff) && !s1_vld_ff && !s2_vld_ff;
   assign finish         = drained && (!last_ff || rsp_free);

   always_comb begin
      cnt_eff = req_chan.new_set ? '0 : cnt_ff;
      pos_eff = req_chan.new_set ? '0 : pos_ff;
      priority if (dim_ff == '0)
         eff_dim = CmpW'(1);
      else if (CmpW'(dim_ff) > CmpW'(DIM_MAX))
         eff_dim = CmpW'(DIM_MAX);
      else
         eff_dim = CmpW'(dim_ff);
      last_eff = (CmpW'(pos_eff) + CmpW'(1)) >= eff_dim;
      wr_ok    = cnt_eff < CntW'(MAX_KEPT);
      wr_addr  = AddrW'(int'(cnt_eff) * DIM_MAX + int'(pos_eff));
      rd_addr  = AddrW'(int'(j_ff[JW-1:0]) * DIM_MAX + int'(pos_ff));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RUN;
         ST_RUN:  if (finish) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
         dim_ff <= VDIM_W'(1);
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_THRESHOLD: thr_ff <= csr_chan.data;
            CSR_DIM:       dim_ff <= csr_chan.data[VDIM_W-1:0];
            default: ;
         endcase
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (accept && wr_ok) store_mem[wr_addr] <= req_chan.component;
      if (issue) store_rd_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff) acc_mem[s2_j_ff] <= sat;
      if (issue) acc_rd_ff <= acc_mem[j_ff[JW-1:0]];
   end

   // stage 1: difference and square
   always_comb begin
      diff     = {comp_ff[COMP_W-1], comp_ff} - {store_rd_ff[COMP_W-1], store_rd_ff};
      diff_neg = ~diff + (COMP_W+1)'(1);
      mag      = diff[COMP_W] ? diff_neg[COMP_W-1:0] : diff[COMP_W-1:0];
      sq       = mag * mag;
   end

   // stage 2: saturating accumulate
   always_comb begin
      sum = {1'b0, acc_old_ff} + (ACC_W+1)'(sq_ff);
      sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         sq_ff      <= sq;
         acc_old_ff <= (pos_ff == '0) ? '0 : acc_rd_ff;
         s2_j_ff    <= s1_j_ff;
      end
      if (issue) s1_j_ff <= j_ff[JW-1:0];
      if (accept) comp_ff <= req_chan.component;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_comb begin
      room     = cnt_ff < CntW'(MAX_KEPT);
      cnt_next = cnt_ff + CntW'(!dup_ff && room);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         vec_ff  <= '0;
         pos_ff  <= '0;
         j_ff    <= '0;
         last_ff <= 1'b0;
         dup_ff  <= 1'b0;
      end else begin
         if (accept) begin
            if (req_chan.new_set) begin
               cnt_ff <= '0;
               vec_ff <= '0;
            end
            pos_ff  <= pos_eff;
            last_ff <= last_eff;
            j_ff    <= '0;
            dup_ff  <= 1'b0;
         end else if (issue) begin
            j_ff <= j_ff + CntW'(1);
         end
         if (s2_vld_ff && last_ff && (sat < thr_ff)) dup_ff <= 1'b1;
         if (finish) begin
            if (last_ff) begin
               pos_ff <= '0;
               cnt_ff <= cnt_next;
               vec_ff <= vec_ff + VEC_IDX_W'(1);
            end else begin
               pos_ff <= pos_ff + PosW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (finish && last_ff) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish && last_ff) begin
         rsp_idx_ff  <= vec_ff;
         rsp_kept_ff <= !dup_ff;
         rsp_ovf_ff  <= !dup_ff && !room;
         rsp_cnt_ff  <= KEPT_CNT_W'(cnt_next);
      end
   end

   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.vector_index   = rsp_idx_ff;
   assign rsp_chan.kept           = rsp_kept_ff;
   assign rsp_chan.store_overflow = rsp_ovf_ff;
   assign rsp_chan.kept_count     = rsp_cnt_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ndvf_checker.sv =====
`default_nettype none

module ndvf_checker import ndvf_pkg::*; #(
   parameter int MAX_KEPT = 64
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [VEC_IDX_W-1:0]  rsp_vector_index,
   input wire logic                  rsp_kept,
   input wire logic                  rsp_store_overflow,
   input wire logic [KEPT_CNT_W-1:0] rsp_kept_count
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_ovf_needs_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_overflow |-> rsp_kept)
      else $error("overflow flagged on a duplicate");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_overflow |-> rsp_kept_count == KEPT_CNT_W'(MAX_KEPT))
      else $error("overflow flagged with room in the store");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vector_index)
         && $stable(rsp_kept) && $stable(rsp_store_overflow) && $stable(rsp_kept_count))
      else $error("stalled result changed");

endmodule

bind near_duplicate_vector_filter_unit ndvf_checker #(.MAX_KEPT(MAX_KEPT)) u_ndvf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_vector_index   (rsp_chan.vector_index),
   .rsp_kept           (rsp_chan.kept),
   .rsp_store_overflow (rsp_chan.store_overflow),
   .rsp_kept_count     (rsp_chan.kept_count)
);

`default_nettype wire

// ===== tb/sv/near_duplicate_vector_filter_unit_tb.sv =====
`timescale 1ns / 1ps

module near_duplicate_vector_filter_unit_tb;
   import ndvf_pkg::*;

   localparam int DIM_MAX     = 256;
   localparam int MAX_KEPT    = 64;
   localparam int HIST_DIM    = 32;
   localparam int HIST_DEPTH  = 64;
   // extra wait after the last verdict, for the pipeline and the output register
   localparam int DRAIN_WAIT  = 100;
   localparam int CYCLE_LIMIT = 800000;
   localparam logic [ACC_W-1:0] THR_MAX = 41'h100_0000_0000;
   localparam longint unsigned ACC_SAT = (64'd1 << ACC_W) - 64'd1;

   typedef struct packed {
      logic [VEC_IDX_W-1:0]  vector_index;
      logic                  kept;
      logic                  store_overflow;
      logic [KEPT_CNT_W-1:0] kept_count;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ndvf_req_if req ();
   ndvf_rsp_if rsp ();
   ndvf_csr_if csr ();

   near_duplicate_vector_filter_unit #(
      .DIM_MAX  (DIM_MAX),
      .MAX_KEPT (MAX_KEPT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   verdict_type pending_verdicts[$];
   int unsigned fail_count      = 0;
   int unsigned cycle_count     = 0;
   int unsigned items_sent      = 0;
   int unsigned rsp_hold_cycles = 0;
   logic        no_idle         = 1'b0;

   // filter state as the block should hold it
   logic signed [COMP_W-1:0] kept_mem [MAX_KEPT][DIM_MAX];
   longint unsigned          dist_acc [MAX_KEPT];
   int                       kept_n   = 0;
   int                       comp_pos = 0;
   logic [VEC_IDX_W-1:0]     vec_num  = '0;
   logic [ACC_W-1:0]         thr_sq   = '0;
   logic [VDIM_W-1:0]        dim_reg  = 9'd1;

   // vectors sent in the current random set, source of near copies
   logic signed [COMP_W-1:0] vec_hist [HIST_DEPTH][HIST_DIM];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic predict_component(input logic signed [COMP_W-1:0] comp, input logic start_set);
      int       eff_dim;
      int       p;
      int       j;
      int       diff;
      int       mag;
      longint unsigned sum;
      logic     dup;
      logic     ovf;
      verdict_type v;
      dup = 1'b0;
      ovf = 1'b0;
      if (dim_reg == 0) eff_dim = 1;
      else if (dim_reg > DIM_MAX) eff_dim = DIM_MAX;
      else eff_dim = dim_reg;
      if (start_set) begin
         kept_n   = 0;
         comp_pos = 0;
         vec_num  = '0;
         foreach (dist_acc[i]) dist_acc[i] = 0;
      end
      p = (comp_pos >= DIM_MAX) ? DIM_MAX - 1 : comp_pos;
      // the component is staged into the next free slot before comparing
      if (kept_n < MAX_KEPT) kept_mem[kept_n][p] = comp;
      for (j = 0; j < kept_n; j++) begin
         diff = int'(comp) - int'(kept_mem[j][p]);
         mag  = (diff < 0) ? -diff : diff;
         sum  = dist_acc[j] + longint'(mag) * longint'(mag);
         dist_acc[j] = (sum > ACC_SAT) ? ACC_SAT : sum;
      end
      if (p + 1 < eff_dim) begin
         comp_pos = p + 1;
         return;
      end
      for (j = 0; j < kept_n; j++)
         if (dist_acc[j] < 64'(thr_sq)) dup = 1'b1;
      if (!dup) begin
         if (kept_n < MAX_KEPT) kept_n++;
         else ovf = 1'b1;
      end
      v.vector_index   = vec_num;
      v.kept           = !dup;
      v.store_overflow = ovf;
      v.kept_count     = kept_n[KEPT_CNT_W-1:0];
      pending_verdicts.push_back(v);
      vec_num  = vec_num + 1'b1;
      comp_pos = 0;
      foreach (dist_acc[i]) dist_acc[i] = 0;
   endtask

   task automatic send_component(input logic signed [COMP_W-1:0] comp, input logic start_set);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.component <= comp;
      req.new_set   <= start_set;
      do @(posedge clock); while (!req.ready);
      predict_component(comp, start_set);
      items_sent++;
   endtask

   task automatic drain_and_wait();
      req.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ACC_W-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      if (idx == CSR_DIM) dim_reg = value[VDIM_W-1:0];
      else thr_sq = value;
   endtask

   task automatic configure(input int unsigned dim, input logic [ACC_W-1:0] thr);
      drain_and_wait();
      write_csr(CSR_DIM, ACC_W'(dim));
      write_csr(CSR_THRESHOLD, thr);
      csr.valid <= 1'b0;
   endtask

   // vectors before any new_set belong to the set opened by reset
   task automatic test_reset_defaults();
      send_component(16'sh7FFF, 1'b0);
      send_component(16'sh8000, 1'b0);
      send_component(16'sh0000, 1'b0);
   endtask

   task automatic test_threshold_edges();
      int k;
      for (k = 0; k < 2; k++) begin
         configure(2, (k == 0) ? THR_MAX : '0);
         send_component(16'sh7FFF, 1'b1);
         send_component(16'sh8000, 1'b0);
         send_component(16'sh8000, 1'b0);
         send_component(16'sh7FFF, 1'b0);
         send_component(16'sh0000, 1'b0);
         send_component(16'sh0000, 1'b0);
      end
      // distance equal to the threshold is not a duplicate
      configure(1, 41'd100);
      send_component(16'sd0, 1'b1);
      send_component(16'sd10, 1'b0);
      send_component(16'sd9, 1'b0);
   endtask

   task automatic test_dimension_range();
      int k;
      configure(0, '0);
      send_component(16'sd5, 1'b1);
      send_component(-16'sd5, 1'b0);
      send_component(16'sd5, 1'b0);
      // above DIM_MAX clamps: vectors end after 256 components
      configure(300, THR_MAX);
      for (k = 0; k < DIM_MAX; k++) send_component(16'sh7FFF, k == 0);
      for (k = 0; k < DIM_MAX; k++) send_component(16'sh8000, 1'b0);
   endtask

   task automatic test_dim_shrink_mid_vector();
      configure(4, 41'd5);
      send_component(16'sd10, 1'b1);
      send_component(16'sd20, 1'b0);
      send_component(16'sd30, 1'b0);
      send_component(16'sd40, 1'b0);
      send_component(16'sd11, 1'b0);
      send_component(16'sd21, 1'b0);
      // the open vector now ends on its third component
      configure(2, 41'd5);
      send_component(16'sd31, 1'b0);
      send_component(16'sd100, 1'b0);
      send_component(16'sd200, 1'b0);
   endtask

   task automatic test_store_overflow();
      int k;
      configure(1, 41'd1);
      for (k = 0; k < 70; k++) send_component(COMP_W'(k * 900 - 32768), k == 0);
      send_component(COMP_W'(5 * 900 - 32768), 1'b0);
      send_component(COMP_W'(63 * 900 - 32768), 1'b0);
      // kept while full, never stored, so it is not matched later
      send_component(COMP_W'(66 * 900 - 32768), 1'b0);
      send_component(16'sh7FFF, 1'b0);
   endtask

   task automatic test_output_backpressure();
      int k;
      configure(1, '0);
      no_idle         = 1'b1;
      rsp_hold_cycles = 1500;
      for (k = 0; k < 24; k++) send_component(COMP_W'(k * 1000 - 12000), k == 0);
      no_idle = 1'b0;
   endtask

   task automatic run_random_set(input int unsigned n_vec);
      int unsigned dim;
      int unsigned amp;
      int unsigned src;
      int unsigned v;
      int unsigned c;
      int unsigned cut;
      int unsigned hist_n;
      int          val;
      logic        near;
      logic        start;
      longint unsigned thr;
      logic signed [COMP_W-1:0] vec [HIST_DIM];
      dim = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      case ($urandom_range(0, 3))
         0: amp = 0;
         1: amp = 3;
         2: amp = 60;
         default: amp = 2000;
      endcase
      case ($urandom_range(0, 5))
         0: thr = 0;
         1: thr = 64'(THR_MAX);
         2: thr = 1;
         default: thr = longint'(dim) * amp * amp * $urandom_range(1, 3) / 4
                        + $urandom_range(0, 2);
      endcase
      configure(dim, thr[ACC_W-1:0]);
      no_idle = ($urandom_range(0, 3) == 0);
      hist_n  = 0;
      start   = 1'b1;
      for (v = 0; v < n_vec; v++) begin
         near = (hist_n != 0) && ($urandom_range(0, 2) != 0);
         src  = (hist_n != 0) ? $urandom_range(0, hist_n - 1) : 0;
         for (c = 0; c < dim; c++) begin
            if (near) begin
               val = int'(vec_hist[src][c]) + int'($urandom_range(0, 2 * amp)) - int'(amp);
               if (val > 32767) val = 32767;
               else if (val < -32768) val = -32768;
               vec[c] = val[COMP_W-1:0];
            end else begin
               case ($urandom_range(0, 7))
                  0: vec[c] = 16'sh7FFF;
                  1: vec[c] = 16'sh8000;
                  default: vec[c] = COMP_W'($urandom);
               endcase
            end
         end
         // now and then a vector is cut short by a restart of the set
         cut = (dim > 1 && $urandom_range(0, 15) == 0) ? $urandom_range(1, dim - 1) : dim;
         if ($urandom_range(0, 19) == 0) begin
            start  = 1'b1;
            hist_n = 0;
         end
         for (c = 0; c < cut; c++) begin
            send_component(vec[c], start);
            start = 1'b0;
         end
         if (cut < dim) begin
            start  = 1'b1;
            hist_n = 0;
         end else if (hist_n < HIST_DEPTH) begin
            for (c = 0; c < dim; c++) vec_hist[hist_n][c] = vec[c];
            hist_n++;
         end
      end
   endtask

   task automatic test_random_sets();
      int unsigned stop_at;
      stop_at = items_sent + 200;
      while (items_sent < stop_at) run_random_set($urandom_range(2, 20));
      no_idle = 1'b0;
   endtask

   initial begin : rsp_driver
      int unsigned stall;
      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles != 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 17);
         end
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   always @(posedge clock) begin : verdict_check
      verdict_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected transaction: vector_index %0d kept %0d",
                   rsp.vector_index, rsp.kept);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp.vector_index !== want.vector_index) begin
               $error("vector_index: expected %0d, got %0d",
                      want.vector_index, rsp.vector_index);
               fail_count++;
            end
            if (rsp.kept !== want.kept) begin
               $error("kept: expected %0d, got %0d", want.kept, rsp.kept);
               fail_count++;
            end
            if (rsp.store_overflow !== want.store_overflow) begin
               $error("store_overflow: expected %0d, got %0d",
                      want.store_overflow, rsp.store_overflow);
               fail_count++;
            end
            if (rsp.kept_count !== want.kept_count) begin
               $error("kept_count: expected %0d, got %0d", want.kept_count, rsp.kept_count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      foreach (dist_acc[i]) dist_acc[i] = 0;
      req.valid     <= 1'b0;
      req.component <= '0;
      req.new_set   <= 1'b0;
      csr.valid     <= 1'b0;
      csr.index     <= CSR_THRESHOLD;
      csr.data      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_threshold_edges();
      test_dimension_range();
      test_dim_shrink_mid_vector();
      test_store_overflow();
      test_output_backpressure();
      test_random_sets();
      drain_and_wait();

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
